/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is asserted.
`define BRB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked check that also holds through reset.
`define BRB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/brb_pkg.sv */
// ----------------------------------------------------------------------------
// brb_pkg
// Types and constants shared by the byte ring buffer modules.
// ----------------------------------------------------------------------------
package brb_pkg;

	localparam int DEPTH_LOG2_DEF = 6;
	localparam logic [2:0] CAP_LOG2_RESET = 3'd6;

	typedef enum logic [1:0] {
		FUNC_WRITE = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_PEEK  = 2'd2,
		FUNC_CLEAR = 2'd3
	} func_t;

	typedef enum logic {
		ST_IDLE,
		ST_STREAM
	} state_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_WRITE,
		CMD_CLEAR,
		CMD_READ_FIRST,
		CMD_READ_NEXT
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t op;
		logic    peek;
	} cmd_t;

	typedef struct packed {
		logic more;   // first read of a request leaves further bytes to deliver
		logic done;   // current streamed byte is the final one
	} status_t;

endpackage

/* hdl/brb_ctrl.sv */
// ----------------------------------------------------------------------------
// brb_ctrl
// Sequencer: turns accepted items into datapath commands, holds off new
// items while a multi-byte read or peek is streaming.
// ----------------------------------------------------------------------------
module brb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       func,
	input  brb_pkg::status_t status,
	output brb_pkg::cmd_t    cmd,
	output logic             busy
);

	brb_pkg::state_t state_q, state_d;
	logic            take;

	assign take = start & (state_q == brb_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= brb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			brb_pkg::ST_IDLE: begin
				if (take && (brb_pkg::func_t'(func) == brb_pkg::FUNC_READ ||
					brb_pkg::func_t'(func) == brb_pkg::FUNC_PEEK) && status.more) begin
					state_d = brb_pkg::ST_STREAM;
				end
			end
			brb_pkg::ST_STREAM: begin
				if (status.done) begin
					state_d = brb_pkg::ST_IDLE;
				end
			end
			default: state_d = brb_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd.op   = brb_pkg::CMD_NONE;
		cmd.peek = 1'b0;
		busy     = 1'b0;
		case (state_q)
			brb_pkg::ST_IDLE: begin
				if (take) begin
					case (brb_pkg::func_t'(func))
						brb_pkg::FUNC_WRITE: cmd.op = brb_pkg::CMD_WRITE;
						brb_pkg::FUNC_READ:  cmd.op = brb_pkg::CMD_READ_FIRST;
						brb_pkg::FUNC_PEEK: begin
							cmd.op   = brb_pkg::CMD_READ_FIRST;
							cmd.peek = 1'b1;
						end
						brb_pkg::FUNC_CLEAR: cmd.op = brb_pkg::CMD_CLEAR;
						default:             cmd.op = brb_pkg::CMD_NONE;
					endcase
				end
			end
			brb_pkg::ST_STREAM: begin
				cmd.op = brb_pkg::CMD_READ_NEXT;
				busy   = 1'b1;
			end
			default: cmd.op = brb_pkg::CMD_NONE;
		endcase
	end

endmodule

/* hdl/brb_datapath.sv */
// ----------------------------------------------------------------------------
// brb_datapath
// Ring store, pointers, chunk counter, stream counters and result register.
// ----------------------------------------------------------------------------
module brb_datapath #(
	parameter int DEPTH_LOG2 = brb_pkg::DEPTH_LOG2_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  brb_pkg::cmd_t    cmd,
	output brb_pkg::status_t status,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_data,
	input  logic [7:0]       byte_in,
	input  logic             chunk_last,
	input  logic [15:0]      request_count,
	output logic             result_valid,
	output logic [7:0]       data_out,
	output logic             has_data,
	output logic             accepted,
	output logic [5:0]       running_count,
	output logic [5:0]       readable,
	output logic [5:0]       writable,
	output logic             last
);

	// pointer width: ring in use never exceeds 64 slots
	localparam int PW    = (DEPTH_LOG2 < 6) ? DEPTH_LOG2 : 6;
	localparam int AW    = DEPTH_LOG2;
	localparam int DEPTH = 1 << DEPTH_LOG2;

	logic [7:0]    mem [DEPTH];
	logic [7:0]    mem_q;

	logic [2:0]    cap_q;
	logic [PW-1:0] wr_ptr_q, rd_ptr_q, scan_q;
	logic [5:0]    chunk_q, cnt_q, n_q, avail_q;
	logic          peek_q;

	logic [PW-1:0] wr_ptr_d, rd_ptr_d, scan_d, rd_addr;
	logic [5:0]    chunk_d, cnt_d, n_d, avail_d;
	logic          peek_d, mem_we, mem_re;

	logic          v_d, has_d, acc_d, last_d;
	logic [5:0]    run_d, rdbl_d;
	logic          res_v_q, res_has_q, res_acc_q, res_last_q;
	logic [5:0]    res_run_q, res_rdbl_q, res_wrbl_q;

	logic [2:0]    lg;
	logic [6:0]    mask7;
	logic [PW-1:0] mask, held, wr_inc, rd_inc, scan_inc;
	logic [5:0]    held6, mask6, n_req, chunk_inc;

	// capacity in use, clamped to 1..PW
	always_comb begin
		if (cap_q == 3'd0) begin
			lg = 3'd1;
		end else if (cap_q > 3'(PW)) begin
			lg = 3'(PW);
		end else begin
			lg = cap_q;
		end
	end

	assign mask7    = (7'd1 << lg) - 7'd1;
	assign mask     = mask7[PW-1:0];
	assign mask6    = 6'(mask);
	assign held     = (wr_ptr_q - rd_ptr_q) & mask;
	assign held6    = 6'(held);
	assign wr_inc   = (wr_ptr_q + PW'(1)) & mask;
	assign rd_inc   = (rd_ptr_q + PW'(1)) & mask;
	assign scan_inc = (scan_q + PW'(1)) & mask;
	assign n_req    = (request_count < {10'd0, held6}) ? request_count[5:0] : held6;
	assign chunk_inc = (chunk_q != 6'd63) ? chunk_q + 6'd1 : chunk_q;

	assign status.more = n_req > 6'd1;
	assign status.done = (cnt_q + 6'd1) == n_q;

	always_comb begin
		wr_ptr_d = wr_ptr_q;
		rd_ptr_d = rd_ptr_q;
		scan_d   = scan_q;
		chunk_d  = chunk_q;
		cnt_d    = cnt_q;
		n_d      = n_q;
		avail_d  = avail_q;
		peek_d   = peek_q;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		rd_addr  = scan_q;
		v_d      = 1'b0;
		has_d    = 1'b0;
		acc_d    = 1'b0;
		last_d   = 1'b0;
		run_d    = 6'd0;
		rdbl_d   = held6;
		case (cmd.op)
			brb_pkg::CMD_WRITE: begin
				v_d    = 1'b1;
				last_d = 1'b1;
				acc_d  = held != mask;
				if (acc_d) begin
					mem_we   = 1'b1;
					wr_ptr_d = wr_inc;
					run_d    = chunk_inc;
					rdbl_d   = held6 + 6'd1;
				end else begin
					run_d = chunk_q;
				end
				chunk_d = chunk_last ? 6'd0 : run_d;
			end
			brb_pkg::CMD_CLEAR: begin
				v_d      = 1'b1;
				last_d   = 1'b1;
				wr_ptr_d = '0;
				rd_ptr_d = '0;
				rdbl_d   = 6'd0;
			end
			brb_pkg::CMD_READ_FIRST: begin
				v_d = 1'b1;
				if (n_req == 6'd0) begin
					last_d = 1'b1;
				end else begin
					mem_re  = 1'b1;
					rd_addr = rd_ptr_q;
					has_d   = 1'b1;
					run_d   = 6'd1;
					cnt_d   = 6'd1;
					n_d     = n_req;
					avail_d = held6;
					peek_d  = cmd.peek;
					scan_d  = rd_inc;
					last_d  = n_req == 6'd1;
					if (!cmd.peek) begin
						rd_ptr_d = rd_inc;
						rdbl_d   = held6 - 6'd1;
					end
				end
			end
			brb_pkg::CMD_READ_NEXT: begin
				v_d     = 1'b1;
				mem_re  = 1'b1;
				rd_addr = scan_q;
				has_d   = 1'b1;
				cnt_d   = cnt_q + 6'd1;
				run_d   = cnt_d;
				scan_d  = scan_inc;
				last_d  = cnt_d == n_q;
				rdbl_d  = avail_q;
				if (!peek_q) begin
					rd_ptr_d = scan_inc;
					rdbl_d   = avail_q - cnt_d;
				end
			end
			default: begin
				v_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= brb_pkg::CAP_LOG2_RESET;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			chunk_q  <= 6'd0;
			res_v_q  <= 1'b0;
		end else begin
			res_v_q <= v_d;
			chunk_q <= chunk_d;
			if (cfg_we) begin
				cap_q    <= cfg_data;
				wr_ptr_q <= '0;
				rd_ptr_q <= '0;
			end else begin
				wr_ptr_q <= wr_ptr_d;
				rd_ptr_q <= rd_ptr_d;
			end
		end
	end

	// stream bookkeeping and result fields: payload, no reset
	always_ff @(posedge clk) begin
		scan_q     <= scan_d;
		cnt_q      <= cnt_d;
		n_q        <= n_d;
		avail_q    <= avail_d;
		peek_q     <= peek_d;
		res_has_q  <= has_d;
		res_acc_q  <= acc_d;
		res_last_q <= last_d;
		res_run_q  <= run_d;
		res_rdbl_q <= rdbl_d;
		res_wrbl_q <= mask6 - rdbl_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[AW'(wr_ptr_q)] <= byte_in;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			mem_q <= mem[AW'(rd_addr)];
		end
	end

	assign result_valid  = res_v_q;
	assign data_out      = res_has_q ? mem_q : 8'd0;
	assign has_data      = res_has_q;
	assign accepted      = res_acc_q;
	assign running_count = res_run_q;
	assign readable      = res_rdbl_q;
	assign writable      = res_wrbl_q;
	assign last          = res_last_q;

endmodule

/* hdl/byte_ring_buffer.sv */
// ----------------------------------------------------------------------------
// byte_ring_buffer
// Byte FIFO in a power-of-two ring with one slot kept empty.
// ----------------------------------------------------------------------------
//
// channel   | handshake                    | payload
// ----------+------------------------------+-----------------------------------
// item in   | start, busy (take: st & !bsy)| func, byte_in, chunk_last,
//           |                              | request_count
// result    | result_valid (1-cycle strobe)| data_out, has_data, accepted,
//           |                              | running_count, readable, writable,
//           |                              | last
// config    | cfg_valid, cfg_ready         | cfg_data (capacity_log2)
//
// Results: every result leaves the output register, which captures it at
//   the edge that issues it. Write, clear and empty read/peek give one
//   result; busy stays low, so such items may follow back to back.
// A read or peek delivering n bytes gives n results (one store read port,
//   one byte per cycle); busy is high while the bytes after the first go out.
// Reset: arst_n clears pointers, chunk count and sequencer; capacity_log2
//   returns to 6. Store contents are left as they are - no clearing pass.
// Stalls: none on the result side, the receiver takes every strobe.
// cfg_ready follows !busy; a config write also zeroes both pointers.
// ----------------------------------------------------------------------------
module byte_ring_buffer #(
	parameter int DEPTH_LOG2 = brb_pkg::DEPTH_LOG2_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// item in
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [7:0]  byte_in,
	input  logic        chunk_last,
	input  logic [15:0] request_count,
	// config
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_data,
	// results
	output logic        result_valid,
	output logic [7:0]  data_out,
	output logic        has_data,
	output logic        accepted,
	output logic [5:0]  running_count,
	output logic [5:0]  readable,
	output logic [5:0]  writable,
	output logic        last
);

	brb_pkg::cmd_t    cmd;
	brb_pkg::status_t status;
	logic             cfg_we;

	// the user must write capacity only between items; the block blocks it only while streaming
	assign cfg_ready = ~busy;
	assign cfg_we    = cfg_valid & cfg_ready;

	brb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	brb_datapath #(
		.DEPTH_LOG2 (DEPTH_LOG2)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.byte_in       (byte_in),
		.chunk_last    (chunk_last),
		.request_count (request_count),
		.result_valid  (result_valid),
		.data_out      (data_out),
		.has_data      (has_data),
		.accepted      (accepted),
		.running_count (running_count),
		.readable      (readable),
		.writable      (writable),
		.last          (last)
	);

endmodule

/* hdl/brb_checker.sv */
// ----------------------------------------------------------------------------
// brb_checker
// Port-level checks on the byte ring buffer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       busy,
	input logic       result_valid,
	input logic [7:0] data_out,
	input logic       has_data,
	input logic       accepted,
	input logic [5:0] readable,
	input logic [5:0] writable,
	input logic       last
);

	// each streaming cycle issues a byte that shows up next cycle
	`BRB_ASSERT(a_stream_result, busy |=> result_valid && has_data, "streaming cycle gave no byte")

	// end of a stream is the item's final result
	`BRB_ASSERT(a_stream_last, $fell(busy) |-> result_valid && last, "stream ended without last")

	// empty results carry a zero byte; data results never flag a stored write
	`BRB_ASSERT(a_empty_zero, result_valid && !has_data |-> data_out == 8'd0, "empty result with data")
	`BRB_ASSERT(a_data_no_acc, result_valid && has_data |-> !accepted, "read result marked accepted")

	// held plus free is the ring's usable size, 1..63
	`BRB_ASSERT(a_fill_sum, result_valid |-> ({1'b0, readable} + {1'b0, writable}) != 7'd0 && ({1'b0, readable} + {1'b0, writable}) <= 7'd63, "readable plus writable out of range")

endmodule

bind byte_ring_buffer brb_checker u_brb_checker (.*);
